>>> src/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

   localparam int HEAP_MAX_BYTES = 65536;
   localparam int HEAP_MIN_BYTES = 4096;
   localparam int HEADER_BYTES   = 8;
   localparam int CHUNK_WORDS    = HEAP_MAX_BYTES / 4;
   localparam int CHUNK_AW       = $clog2(CHUNK_WORDS);

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [16:0] request_bytes;
      logic [15:0] data_offset_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] data_offset_out;
   } rsp_type;

   // One free-list entry: chunk offset and length including header.
   typedef struct packed {
      logic [15:0] start;
      logic [16:0] len;
   } free_entry_type;

   // One chunk-table word: allocated flag and chunk length.
   typedef struct packed {
      logic        alloc;
      logic [16:0] len;
   } chunk_entry_type;

endpackage

>>> src/first_fit_heap_allocator_top.sv
// Top level: request sequencer of the first-fit heap allocator.
//
// Usage: raise start with req_payload while busy is low; that beat is taken.
// Allocate (kind 0) asks for request_bytes, free (kind 1) returns the chunk
// whose data area starts at data_offset_in. Exactly one result beat follows
// on rsp_payload, marked by rsp_valid for one cycle; the receiver cannot
// stall it. busy stays high after an accepted beat until its result shows;
// a beat that is rejected at once leaves busy low and answers next cycle.
// The heap size is written on csr_data with csr_valid/csr_ready, only while
// no request is in flight; a write rebuilds the heap.
// An allocate scans the free list in order, each entry visited costing a
// read and a check, and shifts the entries behind a whole chunk that leaves
// the list. A free checks the chunk table, scans the entries below the chunk,
// then shifts entries on a double merge or an insert. Every entry moved costs
// a read and a write, as the list memory has a registered read port.
// One request at a time.
// Reset and every heap-size write start a clearing pass over every word of
// the chunk table, during which busy is high and no request is taken.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
   parameter int MAX_FREE_CHUNKS = 8192,
   parameter int MIN_SPLIT_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);

   localparam int IDXW = $clog2(MAX_FREE_CHUNKS);
   localparam int CNTW = IDXW + 1;
   localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_FREE_CHUNKS);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_A_RD   = 4'd2;
   localparam logic [3:0] S_A_CHK  = 4'd3;
   localparam logic [3:0] S_SH_RD  = 4'd4;
   localparam logic [3:0] S_SH_WR  = 4'd5;
   localparam logic [3:0] S_F_CK   = 4'd6;
   localparam logic [3:0] S_F_RD   = 4'd7;
   localparam logic [3:0] S_F_CHK  = 4'd8;
   localparam logic [3:0] S_F_DEC  = 4'd9;
   localparam logic [3:0] S_INS_RD = 4'd10;
   localparam logic [3:0] S_INS_WR = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [16:0]         heap_size_ff, heap_size_in;
   logic [CNTW-1:0]     count_ff, count_in;
   logic [CNTW-1:0]     idx_ff, idx_in;
   logic [CNTW-1:0]     pos_ff, pos_in;
   logic [CHUNK_AW-1:0] clr_ff, clr_in;
   logic [17:0]         need_ff, need_in;
   logic [15:0]         h_ff, h_in;
   logic [16:0]         size_ff, size_in;
   free_entry_type      prev_ff, prev_in;
   free_entry_type      next_ff, next_in;
   logic                next_ok_ff, next_ok_in;
   logic [1:0]          st_ff, st_in;
   logic [15:0]         off_ff, off_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                lw_en, lr_en;
   logic [IDXW-1:0]     lw_addr, lr_addr;
   free_entry_type      lw_data, lr_data;
   logic                cw_en;
   logic [CHUNK_AW-1:0] cw_addr, cr_addr;
   chunk_entry_type     cw_data, cr_data;

   logic [17:0]         csr_sz, csr_rnd;
   logic [17:0]         req_rnd;
   logic [15:0]         req_h;
   logic [18:0]         split_lim;
   logic                prev_touch, next_touch;
   logic [CNTW-1:0]     pm1;

   ffha_list_ram #(.DEPTH(MAX_FREE_CHUNKS)) u_list (
      .clock   (clock),
      .wr_en   (lw_en),
      .wr_addr (lw_addr),
      .wr_data (lw_data),
      .rd_en   (lr_en),
      .rd_addr (lr_addr),
      .rd_data (lr_data)
   );

   ffha_chunk_ram u_chunk (
      .clock   (clock),
      .wr_en   (cw_en),
      .wr_addr (cw_addr),
      .wr_data (cw_data),
      .rd_addr (cr_addr),
      .rd_data (cr_data)
   );

   assign busy        = (state_ff != S_IDLE);
   assign csr_ready   = (state_ff == S_IDLE) || (state_ff == S_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // effective heap size: at least the minimum, rounded to words, capped
   always_comb begin
      csr_sz  = (csr_data < 17'(HEAP_MIN_BYTES)) ? 18'(HEAP_MIN_BYTES) : {1'b0, csr_data};
      csr_rnd = (csr_sz + 18'd3) & ~18'd3;
      if (csr_rnd > 18'(HEAP_MAX_BYTES)) begin
         csr_rnd = 18'(HEAP_MAX_BYTES);
      end
   end

   assign req_rnd   = ((18'(req_payload.request_bytes) + 18'd3) & ~18'd3)
                      + 18'(HEADER_BYTES);
   assign req_h     = req_payload.data_offset_in - 16'(HEADER_BYTES);
   assign split_lim = {1'b0, need_ff} + 19'(MIN_SPLIT_BYTES);
   assign pm1       = pos_ff - CNTW'(1);
   assign prev_touch = (pos_ff != '0)
                       && ({1'b0, prev_ff.start} + {1'b0, prev_ff.len} == {2'b0, h_ff});
   assign next_touch = next_ok_ff && ({1'b0, next_ff.start} == {1'b0, h_ff} + size_ff);

   always_comb begin
      state_in     = state_ff;
      heap_size_in = heap_size_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      clr_in       = clr_ff;
      need_in      = need_ff;
      h_in         = h_ff;
      size_in      = size_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      next_ok_in   = next_ok_ff;
      st_in        = st_ff;
      off_in       = off_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      lw_en        = 1'b0;
      lw_addr      = '0;
      lw_data      = '0;
      lr_en        = 1'b0;
      lr_addr      = '0;
      cw_en        = 1'b0;
      cw_addr      = h_ff[CHUNK_AW+1:2];
      cw_data      = '{alloc: 1'b0, len: size_ff};
      cr_addr      = req_h[CHUNK_AW+1:2];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               h_in = req_h;
               if (req_payload.kind == KIND_ALLOC) begin
                  need_in = req_rnd;
                  idx_in  = '0;
                  if (req_payload.request_bytes == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ST_NO_FIT, data_offset_out: '0};
                  end else begin
                     state_in = S_A_RD;
                  end
               end else if (req_payload.data_offset_in < 16'(HEADER_BYTES)
                            || req_h[1:0] != 2'b00
                            || {1'b0, req_h} >= heap_size_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_BAD, data_offset_out: '0};
               end else begin
                  state_in = S_F_CK;
               end
            end
         end

         S_CLEAR: begin
            cw_en   = 1'b1;
            cw_addr = clr_ff;
            cw_data = '0;
            lw_en   = 1'b1;
            lw_data = '{start: '0, len: heap_size_ff};
            clr_in  = clr_ff + CHUNK_AW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         S_A_RD: begin
            if (idx_ff >= count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_NO_FIT, data_offset_out: '0};
               state_in     = S_IDLE;
            end else begin
               lr_en    = 1'b1;
               lr_addr  = idx_ff[IDXW-1:0];
               state_in = S_A_CHK;
            end
         end

         S_A_CHK: begin
            if ({1'b0, lr_data.len} >= need_ff) begin
               h_in    = lr_data.start;
               cw_en   = 1'b1;
               cw_addr = lr_data.start[CHUNK_AW+1:2];
               if ({2'b0, lr_data.len} < split_lim) begin
                  // whole chunk goes: drop the entry
                  cw_data  = '{alloc: 1'b1, len: lr_data.len};
                  st_in    = ST_OK;
                  off_in   = lr_data.start + 16'(HEADER_BYTES);
                  state_in = S_SH_RD;
               end else begin
                  cw_data      = '{alloc: 1'b1, len: need_ff[16:0]};
                  lw_en        = 1'b1;
                  lw_addr      = idx_ff[IDXW-1:0];
                  lw_data      = '{start: lr_data.start + need_ff[15:0],
                                   len: lr_data.len - need_ff[16:0]};
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_OK,
                                   data_offset_out: lr_data.start + 16'(HEADER_BYTES)};
                  state_in     = S_IDLE;
               end
            end else begin
               idx_in   = idx_ff + CNTW'(1);
               state_in = S_A_RD;
            end
         end

         S_SH_RD: begin
            if (idx_ff + CNTW'(1) >= count_ff) begin
               count_in     = count_ff - CNTW'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: st_ff, data_offset_out: off_ff};
               state_in     = S_IDLE;
            end else begin
               lr_en    = 1'b1;
               lr_addr  = IDXW'(idx_ff + CNTW'(1));
               state_in = S_SH_WR;
            end
         end

         S_SH_WR: begin
            lw_en    = 1'b1;
            lw_addr  = idx_ff[IDXW-1:0];
            lw_data  = lr_data;
            idx_in   = idx_ff + CNTW'(1);
            state_in = S_SH_RD;
         end

         S_F_CK: begin
            if (!cr_data.alloc) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_BAD, data_offset_out: '0};
               state_in     = S_IDLE;
            end else begin
               size_in  = cr_data.len;
               idx_in   = '0;
               state_in = S_F_RD;
            end
         end

         S_F_RD: begin
            if (idx_ff < count_ff) begin
               lr_en    = 1'b1;
               lr_addr  = idx_ff[IDXW-1:0];
               state_in = S_F_CHK;
            end else begin
               next_ok_in = 1'b0;
               pos_in     = idx_ff;
               state_in   = S_F_DEC;
            end
         end

         S_F_CHK: begin
            if (lr_data.start <= h_ff) begin
               prev_in  = lr_data;
               idx_in   = idx_ff + CNTW'(1);
               state_in = S_F_RD;
            end else begin
               next_in    = lr_data;
               next_ok_in = 1'b1;
               pos_in     = idx_ff;
               state_in   = S_F_DEC;
            end
         end

         S_F_DEC: begin
            st_in  = ST_OK;
            off_in = '0;
            if (prev_touch && next_touch) begin
               lw_en    = 1'b1;
               lw_addr  = pm1[IDXW-1:0];
               lw_data  = '{start: prev_ff.start,
                            len: prev_ff.len + size_ff + next_ff.len};
               cw_en    = 1'b1;
               idx_in   = pos_ff;
               state_in = S_SH_RD;
            end else if (prev_touch) begin
               lw_en        = 1'b1;
               lw_addr      = pm1[IDXW-1:0];
               lw_data      = '{start: prev_ff.start, len: prev_ff.len + size_ff};
               cw_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_OK, data_offset_out: '0};
               state_in     = S_IDLE;
            end else if (next_touch) begin
               lw_en        = 1'b1;
               lw_addr      = pos_ff[IDXW-1:0];
               lw_data      = '{start: h_ff, len: next_ff.len + size_ff};
               cw_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_OK, data_offset_out: '0};
               state_in     = S_IDLE;
            end else if (count_ff >= MAX_CNT) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_NO_FIT, data_offset_out: '0};
               state_in     = S_IDLE;
            end else begin
               cw_en    = 1'b1;
               idx_in   = count_ff;
               state_in = S_INS_RD;
            end
         end

         S_INS_RD: begin
            if (idx_ff == pos_ff) begin
               lw_en        = 1'b1;
               lw_addr      = pos_ff[IDXW-1:0];
               lw_data      = '{start: h_ff, len: size_ff};
               count_in     = count_ff + CNTW'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_OK, data_offset_out: '0};
               state_in     = S_IDLE;
            end else begin
               lr_en    = 1'b1;
               lr_addr  = IDXW'(idx_ff - CNTW'(1));
               state_in = S_INS_WR;
            end
         end

         S_INS_WR: begin
            lw_en    = 1'b1;
            lw_addr  = idx_ff[IDXW-1:0];
            lw_data  = lr_data;
            idx_in   = idx_ff - CNTW'(1);
            state_in = S_INS_RD;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // heap-size write: rebuild the heap from scratch
      if (csr_valid && csr_ready) begin
         heap_size_in = csr_rnd[16:0];
         count_in     = CNTW'(1);
         clr_in       = '0;
         state_in     = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         heap_size_ff <= 17'(HEAP_MIN_BYTES);
         count_ff     <= CNTW'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_size_ff <= heap_size_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      need_ff    <= need_in;
      h_ff       <= h_in;
      size_ff    <= size_in;
      prev_ff    <= prev_in;
      next_ff    <= next_in;
      next_ok_ff <= next_ok_in;
      st_ff      <= st_in;
      off_ff     <= off_in;
      rsp_ff     <= rsp_in;
   end

endmodule

>>> src/ffha_list_ram.sv
// Free-list memory: one write port, one registered read port.
module ffha_list_ram import ffha_pkg::*; #(
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  free_entry_type           wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output free_entry_type           rd_data
);

   free_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/ffha_chunk_ram.sv
// Chunk table memory: one word per 4-byte heap word, registered read.
module ffha_chunk_ram import ffha_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [CHUNK_AW-1:0] wr_addr,
   input  chunk_entry_type     wr_data,
   input  logic [CHUNK_AW-1:0] rd_addr,
   output chunk_entry_type     rd_data
);

   chunk_entry_type mem [CHUNK_WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
